// ===== design/serial_frame_segmenter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SERIAL_FRAME_SEGMENTER_DEFINES_SVH
`define SERIAL_FRAME_SEGMENTER_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define SFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sfs_pkg.sv =====
package sfs_pkg;

    localparam int BYTE_W      = 8;
    localparam int MSG_LEN_W   = 16;
    localparam int MAX_PAYLOAD = 254;
    localparam int LENGTH_BITS = 16;

    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG   = 2'd3;

    localparam logic [BYTE_W-1:0] START_RST = 8'd22;
    localparam logic [BYTE_W-1:0] DEST_RST  = 8'd84;
    localparam logic [BYTE_W-1:0] CTRL_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] TAG_RST   = 8'd48;

    // Input word kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    typedef logic [BYTE_W-1:0]      t_byte;
    typedef logic [LENGTH_BITS-1:0] t_len;

endpackage

// ===== design/sfs_in_if.sv =====
interface sfs_in_if;
    import sfs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [MSG_LEN_W-1:0] message_length;
    logic [BYTE_W-1:0]    data_byte;

    modport source (output valid, kind, message_length, data_byte, input ready);
    modport sink   (input valid, kind, message_length, data_byte, output ready);
endinterface

// ===== design/sfs_out_if.sv =====
interface sfs_out_if;
    import sfs_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              message_end;

    modport source (output valid, out_byte, frame_end, message_end, input ready);
    modport sink   (input valid, out_byte, frame_end, message_end, output ready);
endinterface

// ===== design/serial_frame_segmenter.sv =====
// Channel   Direction  Word contents
// i_in      in         kind, message_length, data_byte
// o_out     out        out_byte, frame_end, message_end
// i_cfg_*   in         write enable, register index, register data
//
// A data word that opens a frame yields six or seven output words (header, length,
// data and maybe check); any other data word yields one or two, a start word or a data word outside a message none.
// A new input word is taken in the cycle the previous output group's last word
// leaves, so plain data words stream at one word per cycle while output is not stalled.
// The output group register is the only limit: it holds one word's results.
// Reset is synchronous and active low; it restores the header registers and
// closes any message. Output stalls hold the group register and input ready.
module serial_frame_segmenter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    sfs_in_if.sink                    i_in,
    sfs_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sfs_pkg::BYTE_W-1:0]    i_cfg_data
);
    import sfs_pkg::*;

    // Position of the word being shown within the output group.
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_DEST  = 3'd1;
    localparam logic [2:0] PH_CTRL  = 3'd2;
    localparam logic [2:0] PH_TAG   = 3'd3;
    localparam logic [2:0] PH_LEN   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CHECK = 3'd6;

    // Header bytes written through the configuration port.
    t_byte r_cfg_start, r_cfg_dest, r_cfg_ctrl, r_cfg_tag;

    // Framing state.
    t_len  r_msg_left, n_msg_left;
    t_byte r_frame_left, n_frame_left;
    t_byte r_check, n_check;
    logic  r_frame_open, n_frame_open;

    // Output group: everything one data word produces.
    logic       r_grp_valid;
    logic [2:0] r_phase;
    logic       r_grp_hdr;
    t_byte      r_grp_len;
    t_byte      r_grp_data;
    logic       r_grp_chk_en;
    t_byte      r_grp_chk;
    logic       r_grp_me;

    logic       in_fire, out_fire, grp_last, grp_done;
    logic       n_load;
    t_byte      flen, chk_base, chk_next, chk_out, fl_next;
    t_len       ml_next;
    logic       frame_close;
    t_byte      out_mux;

    assign out_fire = r_grp_valid & o_out.ready;
    assign grp_last = r_grp_chk_en ? (r_phase == PH_CHECK) : (r_phase == PH_DATA);
    assign grp_done = out_fire & grp_last;

    // A new word may enter when no group is pending or the last one is leaving now.
    assign i_in.ready = ~r_grp_valid | grp_done;
    assign in_fire    = i_in.valid & i_in.ready;

    // Per-word framing logic: all results of one data word are formed here.
    always_comb begin
        if (r_frame_open) begin
            flen     = r_frame_left;
            chk_base = r_check;
        end else begin
            flen     = (r_msg_left > LENGTH_BITS'(MAX_PAYLOAD)) ? BYTE_W'(MAX_PAYLOAD)
                                                               : r_msg_left[BYTE_W-1:0];
            chk_base = '0;
        end
        chk_next    = chk_base ^ i_in.data_byte;
        fl_next     = flen - BYTE_W'(1);
        ml_next     = r_msg_left - LENGTH_BITS'(1);
        frame_close = (fl_next == '0);
        // A check value of all zeros or all ones is replaced by one.
        chk_out     = ((chk_next == '0) || (chk_next == '1)) ? BYTE_W'(1) : chk_next;

        n_msg_left   = r_msg_left;
        n_frame_left = r_frame_left;
        n_check      = r_check;
        n_frame_open = r_frame_open;
        n_load       = 1'b0;

        if (i_in.kind == KIND_START) begin
            n_msg_left   = LENGTH_BITS'(i_in.message_length);
            n_frame_left = '0;
            n_check      = '0;
            n_frame_open = 1'b0;
        end else if (r_msg_left != '0) begin
            // Data words outside a message are dropped silently.
            n_load       = 1'b1;
            n_msg_left   = ml_next;
            n_frame_left = fl_next;
            n_check      = frame_close ? '0 : chk_next;
            n_frame_open = ~frame_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start <= START_RST;
            r_cfg_dest  <= DEST_RST;
            r_cfg_ctrl  <= CTRL_RST;
            r_cfg_tag   <= TAG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START: r_cfg_start <= i_cfg_data;
                CFG_DEST:  r_cfg_dest  <= i_cfg_data;
                CFG_CTRL:  r_cfg_ctrl  <= i_cfg_data;
                CFG_TAG:   r_cfg_tag   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_left   <= '0;
            r_frame_left <= '0;
            r_check      <= '0;
            r_frame_open <= 1'b0;
        end else if (in_fire) begin
            r_msg_left   <= n_msg_left;
            r_frame_left <= n_frame_left;
            r_check      <= n_check;
            r_frame_open <= n_frame_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_phase     <= PH_START;
        end else if (in_fire) begin
            r_grp_valid <= n_load;
            r_phase     <= r_frame_open ? PH_DATA : PH_START;
        end else if (out_fire) begin
            if (grp_last) begin
                r_grp_valid <= 1'b0;
            end else begin
                r_phase <= r_phase + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_grp_hdr    <= ~r_frame_open;
            r_grp_len    <= flen;
            r_grp_data   <= i_in.data_byte;
            r_grp_chk_en <= frame_close;
            r_grp_chk    <= chk_out;
            r_grp_me     <= (ml_next == '0);
        end
    end

    always_comb begin
        unique case (r_phase)
            PH_START: out_mux = r_cfg_start;
            PH_DEST:  out_mux = r_cfg_dest;
            PH_CTRL:  out_mux = r_cfg_ctrl;
            PH_TAG:   out_mux = r_cfg_tag;
            PH_LEN:   out_mux = r_grp_len;
            PH_DATA:  out_mux = r_grp_data;
            PH_CHECK: out_mux = r_grp_chk;
            default:  out_mux = '0;
        endcase
    end

    // The header flag and the phase together gate valid; a group without a header starts at the data phase.
    assign o_out.valid       = r_grp_valid & (r_grp_hdr | (r_phase >= PH_DATA));
    assign o_out.out_byte    = out_mux;
    assign o_out.frame_end   = (r_phase == PH_CHECK);
    assign o_out.message_end = (r_phase == PH_CHECK) & r_grp_me;

endmodule

// ===== design/sfs_checker.sv =====
`include "serial_frame_segmenter_defines.svh"

module sfs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [sfs_pkg::BYTE_W-1:0] i_out_byte,
    input logic                       i_frame_end,
    input logic                       i_message_end
);
    import sfs_pkg::*;

    `SFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_frame_end), "output word changed while stalled")
    `SFS_ASSERT_NOW(a_msg_end_on_frame_end, i_clk, i_rst_n, i_out_valid && i_message_end, i_frame_end, "message end without frame end")
    `SFS_ASSERT_NOW(a_idle_takes_input, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input blocked with no output pending")
    `SFS_ASSERT_NOW(a_check_range, i_clk, i_rst_n, i_out_valid && i_frame_end, (i_out_byte != 8'h00) && (i_out_byte != 8'hFF), "check byte is zero or all ones")

endmodule

bind serial_frame_segmenter sfs_checker u_sfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_frame_end   (o_out.frame_end),
    .i_message_end (o_out.message_end)
);
